[rtl/core/uleb_pkg.sv]
// ----------------------------------------------------------------------------
// uleb_pkg
// Shared widths, status codes and the result record of the varint decoder.
// ----------------------------------------------------------------------------
package uleb_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned GROUP_W = 7;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned SHIFT_W = 7;

	localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h7f;
	localparam logic [BYTE_W-1:0] HIGH_MASK    = 8'h7e;
	localparam logic [BYTE_W-1:0] CONT_MASK    = 8'h80;
	localparam logic [SHIFT_W-1:0] LAST_SHIFT  = 7'd63;
	localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 7'd64;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_OVERFLOW   = 3'd1,
		ST_NONMINIMAL = 3'd2,
		ST_TOOLONG    = 3'd3,
		ST_TRUNCATED  = 3'd4
	} status_t;

	typedef struct packed {
		logic                fire;
		logic [VALUE_W-1:0]  value;
		status_t             status;
	} result_t;

endpackage

[rtl/core/uleb_if.sv]
// ----------------------------------------------------------------------------
// uleb_if
// Valid/ready channels for encoded bytes and for decoded results.
// ----------------------------------------------------------------------------
interface uleb_byte_if;
	logic                          valid;
	logic                          ready;
	logic [uleb_pkg::BYTE_W-1:0]   data_byte;
	logic                          buffer_end;

	modport source (output valid, output data_byte, output buffer_end, input ready);
	modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface uleb_result_if;
	logic                          valid;
	logic                          ready;
	logic [uleb_pkg::VALUE_W-1:0]  value;
	logic [2:0]                    status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

[rtl/core/strict_uleb128_decoder_core.sv]
// ----------------------------------------------------------------------------
// strict_uleb128_decoder_core
// Strict unsigned LEB128 decoder producing 64-bit values, one byte a cycle while results are taken.
// ----------------------------------------------------------------------------
// The bytes channel carries one encoded byte per transaction together with
// buffer_end, which marks the last byte of the buffer. The results channel
// carries one transaction per finished varint or per error: value holds the
// decoded number for status ok and zero otherwise; status is ok, overflow,
// non-minimal, too long or truncated. Bytes that only extend a varint give
// no result transaction.
// A byte is taken into an input register, decoded combinationally against the
// running value and byte index, and any result lands in an output register
// that drives the results port.
// One byte is accepted every cycle while the receiver takes results. When it stalls, the held
// result stays on the port and bytes keep flowing until another result has
// to wait behind it; then the input register fills and ready drops.
// Reset clears the running value, the byte index and both valid flags; no
// clearing pass is needed afterwards.
// ----------------------------------------------------------------------------
module strict_uleb128_decoder_core #(
	parameter int unsigned MAX_VARINT_BYTES = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	uleb_byte_if.sink     bytes,
	uleb_result_if.source results
);

	logic                         valid_s1;
	logic [uleb_pkg::BYTE_W-1:0]  data_byte_s1;
	logic                         buffer_end_s1;
	logic                         advance;
	logic                         consume;
	uleb_pkg::result_t            res;
	logic                         valid_s2;
	logic [uleb_pkg::VALUE_W-1:0] value_s2;
	uleb_pkg::status_t            status_s2;

	// A byte may leave the input register unless it makes a result that
	// cannot yet enter the output register.
	assign advance = !res.fire || !valid_s2 || results.ready;
	assign consume = valid_s1 && advance;

	uleb_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (bytes.valid),
		.in_ready      (bytes.ready),
		.in_byte       (bytes.data_byte),
		.in_end        (bytes.buffer_end),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.data_byte_s1  (data_byte_s1),
		.buffer_end_s1 (buffer_end_s1)
	);

	uleb_decode #(
		.MAX_VARINT_BYTES (MAX_VARINT_BYTES)
	) u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.consume       (consume),
		.data_byte_s1  (data_byte_s1),
		.buffer_end_s1 (buffer_end_s1),
		.res           (res)
	);

	uleb_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (consume && res.fire),
		.res       (res),
		.out_ready (results.ready),
		.valid_s2  (valid_s2),
		.value_s2  (value_s2),
		.status_s2 (status_s2)
	);

	assign results.valid  = valid_s2;
	assign results.value  = value_s2;
	assign results.status = status_s2;

endmodule

[rtl/core/uleb_in_reg.sv]
// ----------------------------------------------------------------------------
// uleb_in_reg
// Input register: holds one accepted byte until the decode step consumes it.
// ----------------------------------------------------------------------------
module uleb_in_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [uleb_pkg::BYTE_W-1:0] in_byte,
	input  logic                        in_end,
	input  logic                        advance,
	output logic                        valid_s1,
	output logic [uleb_pkg::BYTE_W-1:0] data_byte_s1,
	output logic                        buffer_end_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_byte_s1  <= in_byte;
			buffer_end_s1 <= in_end;
		end
	end

endmodule

[rtl/core/uleb_decode.sv]
// ----------------------------------------------------------------------------
// uleb_decode
// Varint state and the per-byte merge, completion and error checks.
// ----------------------------------------------------------------------------
module uleb_decode #(
	parameter int unsigned MAX_VARINT_BYTES = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        consume,
	input  logic [uleb_pkg::BYTE_W-1:0] data_byte_s1,
	input  logic                        buffer_end_s1,
	output uleb_pkg::result_t           res
);

	localparam logic [uleb_pkg::IDX_W-1:0] MAX_BYTES = uleb_pkg::IDX_W'(MAX_VARINT_BYTES);

	logic [uleb_pkg::VALUE_W-1:0] partial_q;
	logic [uleb_pkg::IDX_W-1:0]   idx_q;

	logic [uleb_pkg::SHIFT_W-1:0] shift_amt;
	logic [uleb_pkg::VALUE_W-1:0] group_ext;
	logic [uleb_pkg::VALUE_W-1:0] merged;
	logic [uleb_pkg::IDX_W-1:0]   idx_inc;
	logic                         overflow;
	logic                         cont;

	always_comb begin
		shift_amt = uleb_pkg::SHIFT_W'({3'b000, idx_q} * 7'd7);
		group_ext = {{(uleb_pkg::VALUE_W - uleb_pkg::BYTE_W){1'b0}},
			data_byte_s1 & uleb_pkg::PAYLOAD_MASK};
		merged    = partial_q;
		if (shift_amt < uleb_pkg::SHIFT_LIMIT) begin
			merged = partial_q | (group_ext << shift_amt[5:0]);
		end
		overflow  = (shift_amt == uleb_pkg::LAST_SHIFT) &&
			((data_byte_s1 & uleb_pkg::HIGH_MASK) != '0);
		cont      = (data_byte_s1 & uleb_pkg::CONT_MASK) != '0;
		idx_inc   = idx_q + 1'b1;

		res.fire   = 1'b1;
		res.value  = '0;
		res.status = uleb_pkg::ST_OK;
		if (overflow) begin
			res.status = uleb_pkg::ST_OVERFLOW;
		end else if (!cont) begin
			// A zero byte after the first one adds nothing and is rejected.
			if (idx_q != '0 && data_byte_s1 == '0) begin
				res.status = uleb_pkg::ST_NONMINIMAL;
			end else begin
				res.value = merged;
			end
		end else if (idx_inc >= MAX_BYTES) begin
			res.status = uleb_pkg::ST_TOOLONG;
		end else if (buffer_end_s1) begin
			res.status = uleb_pkg::ST_TRUNCATED;
		end else begin
			res.fire = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			idx_q     <= '0;
		end else if (consume) begin
			if (res.fire) begin
				partial_q <= '0;
				idx_q     <= '0;
			end else begin
				partial_q <= merged;
				idx_q     <= idx_inc;
			end
		end
	end

endmodule

[rtl/core/uleb_out_reg.sv]
// ----------------------------------------------------------------------------
// uleb_out_reg
// Result register: holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module uleb_out_reg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  uleb_pkg::result_t            res,
	input  logic                         out_ready,
	output logic                         valid_s2,
	output logic [uleb_pkg::VALUE_W-1:0] value_s2,
	output uleb_pkg::status_t            status_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_s2  <= res.value;
			status_s2 <= res.status;
		end
	end

endmodule

[rtl/core/uleb_checker.sv]
// ----------------------------------------------------------------------------
// uleb_checker
// Port-level checks of the varint decoder, bound to the top level.
// ----------------------------------------------------------------------------
module uleb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [uleb_pkg::VALUE_W-1:0] out_value,
	input logic [2:0]                   out_status
);

	// A stalled result keeps its valid flag and its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
		else $error("result changed while stalled");

	// Every error result reports a zero value.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != uleb_pkg::ST_OK |-> out_value == '0)
		else $error("error result carries a nonzero value");

	// The status field only ever shows one of the five defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status == uleb_pkg::ST_OK || out_status == uleb_pkg::ST_OVERFLOW ||
			out_status == uleb_pkg::ST_NONMINIMAL || out_status == uleb_pkg::ST_TOOLONG ||
			out_status == uleb_pkg::ST_TRUNCATED)
		else $error("undefined status code");

	// Nothing is offered in the first cycle after reset is released.
	a_reset_quiet: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("result offered directly after reset");

endmodule

bind strict_uleb128_decoder_core uleb_checker u_uleb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_value  (results.value),
	.out_status (results.status)
);
